@@ sv/sss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Suffix stemmer package
// Character codes shared by the front and back parts of the stemmer.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_Z = 8'h7a;

  localparam int TAIL_DEPTH = 8;

endpackage
`default_nettype wire

@@ sv/sss_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/sss_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word descriptor queue
// Two-entry queue of finished word descriptors between front and back.
// ----------------------------------------------------------------------------
module sss_queue #(
  parameter int WIDTH = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic                  not_empty,
  output logic                  full
);

  logic [WIDTH-1:0] entry [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign head      = entry[rptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range : assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("Descriptor queue count out of range.");
  a_no_overflow : assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("Descriptor pushed into a full queue.");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
      !(pop && !not_empty))
    else $error("Descriptor popped from an empty queue.");
  a_ptr_match : assert property (@(posedge clk) disable iff (rst)
      (count == 2'd0 || count == 2'd2) |-> (wptr == rptr))
    else $error("Queue pointers disagree with the count.");

endmodule
`default_nettype wire

@@ sv/sss_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stemmer front end
// Collects characters into a word bank, tracks the word tail and decides the
// stemmed length at the word end.
// ----------------------------------------------------------------------------
module sss_front
  import sss_pkg::*;
#(
  parameter int MAX_WORD_LEN = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  char_valid,
  output logic                                       char_ready,
  input  wire logic [7:0]                            letter,
  input  wire logic                                  word_end,
  input  wire logic                                  q_full,
  output logic                                       q_push,
  output logic [$clog2(MAX_WORD_LEN+1)+2:0]          q_data,
  output logic                                       ram_we,
  output logic [$clog2(MAX_WORD_LEN):0]              ram_waddr,
  output logic [7:0]                                 ram_wdata
);

  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W = $clog2(MAX_WORD_LEN);

  logic [LEN_W-1:0] word_length;
  logic             overflow_seen;
  logic             wbank;
  logic [7:0]       tail [TAIL_DEPTH];
  logic [7:0]       tail_next [TAIL_DEPTH];

  logic             accept;
  logic             full;
  logic [LEN_W-1:0] len_new;

  logic             sses, ies, ss, s1, ing, ed, cut;
  logic [1:0]       r1;
  logic [1:0]       r2;
  logic [2:0]       sh;
  logic [LEN_W-1:0] n1, n2, n_out;
  logic             e_add;
  logic [7:0]       u [3];
  logic [7:0]       v [3];

  assign char_ready = !q_full;
  assign accept     = char_valid && char_ready;
  assign full       = (word_length == LEN_W'(MAX_WORD_LEN));
  assign len_new    = word_length + {{(LEN_W-1){1'b0}}, !full};

  assign ram_we    = accept && !full;
  assign ram_waddr = {wbank, word_length[IDX_W-1:0]};
  assign ram_wdata = letter;

  always_comb begin
    tail_next[0] = full ? tail[0] : letter;
    for (int i = 1; i < TAIL_DEPTH; i++) begin
      tail_next[i] = full ? tail[i] : tail[i-1];
    end
  end

  always_comb begin
    sses = (len_new > LEN_W'(4)) && tail_next[3] == CH_S && tail_next[2] == CH_S &&
           tail_next[1] == CH_E && tail_next[0] == CH_S;
    ies  = (len_new > LEN_W'(3)) && tail_next[2] == CH_I && tail_next[1] == CH_E &&
           tail_next[0] == CH_S;
    ss   = (len_new > LEN_W'(2)) && tail_next[1] == CH_S && tail_next[0] == CH_S;
    s1   = (len_new > LEN_W'(1)) && tail_next[0] == CH_S;
    if (sses || ies) begin
      r1 = 2'd2;
    end else if (ss) begin
      r1 = 2'd0;
    end else if (s1) begin
      r1 = 2'd1;
    end else begin
      r1 = 2'd0;
    end
    n1 = len_new - {{(LEN_W-2){1'b0}}, r1};
    for (int d = 0; d < 3; d++) begin
      u[d] = tail_next[3'(d) + {1'b0, r1}];
    end

    ing = !sses && !ies && ss ? 1'b0 :
          (n1 > LEN_W'(4)) && u[2] == CH_I && u[1] == CH_N && u[0] == CH_G;
    ed  = !(!sses && !ies && ss) && !ing &&
          (n1 > LEN_W'(3)) && u[1] == CH_E && u[0] == CH_D;
    cut = ing || ed;
    r2  = ing ? 2'd3 : (ed ? 2'd2 : 2'd0);
    n2  = n1 - {{(LEN_W-2){1'b0}}, r2};
    sh  = {1'b0, r1} + {1'b0, r2};
    for (int d = 0; d < 3; d++) begin
      v[d] = tail_next[3'(d) + sh];
    end

    n_out = n2;
    e_add = 1'b0;
    if (cut) begin
      if ((n2 >= LEN_W'(2)) &&
          ((v[1] == CH_A && v[0] == CH_T) || (v[1] == CH_B && v[0] == CH_L) ||
           (v[1] == CH_I && v[0] == CH_Z))) begin
        n_out = n2 + LEN_W'(1);
        e_add = 1'b1;
      end else if ((n2 >= LEN_W'(2)) && v[1] == v[0]) begin
        n_out = n2 - LEN_W'(1);
      end else if ((n2 == LEN_W'(3)) && v[2] == CH_F && v[1] == CH_I && v[0] == CH_L) begin
        n_out = n2 + LEN_W'(1);
        e_add = 1'b1;
      end
    end
  end

  assign q_push = accept && word_end;
  assign q_data = {wbank, overflow_seen | full, e_add, n_out};

  always_ff @(posedge clk) begin
    if (accept && !full) begin
      for (int i = 0; i < TAIL_DEPTH; i++) begin
        tail[i] <= tail_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length   <= '0;
      overflow_seen <= 1'b0;
      wbank         <= 1'b0;
    end else if (accept) begin
      if (word_end) begin
        word_length   <= '0;
        overflow_seen <= 1'b0;
        wbank         <= ~wbank;
      end else begin
        word_length   <= len_new;
        overflow_seen <= overflow_seen | full;
      end
    end
  end

  a_len_bound : assert property (@(posedge clk) disable iff (rst)
      word_length <= LEN_W'(MAX_WORD_LEN))
    else $error("Word length beyond the buffer size.");
  a_ovf_full : assert property (@(posedge clk) disable iff (rst)
      overflow_seen |-> full)
    else $error("Overflow flagged with room left in the buffer.");
  a_push_len : assert property (@(posedge clk) disable iff (rst)
      q_push |-> (n_out != '0) && (n_out <= len_new))
    else $error("Stemmed length out of range.");

endmodule
`default_nettype wire

@@ sv/sss_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stemmer back end
// Reads the stemmed word out of its bank and drives the output register.
// ----------------------------------------------------------------------------
module sss_back
  import sss_pkg::*;
#(
  parameter int MAX_WORD_LEN = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [$clog2(MAX_WORD_LEN+1)+2:0]     q_head,
  input  wire logic                                  q_not_empty,
  output logic                                       q_pop,
  output logic                                       ram_re,
  output logic [$clog2(MAX_WORD_LEN):0]              ram_raddr,
  input  wire logic [7:0]                            ram_rdata,
  output logic                                       stem_valid,
  input  wire logic                                  stem_ready,
  output logic [7:0]                                 out_letter,
  output logic                                       out_end,
  output logic                                       truncated
);

  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W = $clog2(MAX_WORD_LEN);

  logic [LEN_W-1:0] ridx;
  logic             e_last;
  logic             advance;
  logic             last;
  logic [LEN_W-1:0] h_len;
  logic             h_e_add;
  logic             h_trunc;
  logic             h_bank;

  assign {h_bank, h_trunc, h_e_add, h_len} = q_head;

  assign advance   = q_not_empty && (!stem_valid || stem_ready);
  assign last      = (ridx == h_len - LEN_W'(1));
  assign q_pop     = advance && last;
  assign ram_re    = advance;
  assign ram_raddr = {h_bank, ridx[IDX_W-1:0]};
  assign out_letter = e_last ? CH_E : ram_rdata;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_end   <= last;
      e_last    <= last && h_e_add;
      truncated <= h_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stem_valid <= 1'b0;
      ridx       <= '0;
    end else begin
      if (advance) begin
        stem_valid <= 1'b1;
        ridx       <= last ? '0 : ridx + LEN_W'(1);
      end else if (stem_ready) begin
        stem_valid <= 1'b0;
      end
    end
  end

  a_idx_range : assert property (@(posedge clk) disable iff (rst)
      q_not_empty |-> ridx < h_len)
    else $error("Read index past the stemmed length.");
  a_idle_idx : assert property (@(posedge clk) disable iff (rst)
      !q_not_empty |-> ridx == '0)
    else $error("Read index not cleared between words.");
  a_empty_valid : assert property (@(posedge clk) disable iff (rst)
      (!q_not_empty && stem_valid && stem_ready) |=> !stem_valid)
    else $error("Output raised with no word to emit.");

endmodule
`default_nettype wire

@@ sv/suffix_stemmer_step1_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Suffix stemmer, Porter step 1
// Collects a word a character at a time and emits its step 1 stem.
// ----------------------------------------------------------------------------
// The front end takes one character per cycle, while char_ready is high, into
// one of two word banks of a RAM and, on the character marked word_end,
// classifies the word from its last eight stored characters and queues a
// descriptor. The back end reads the stemmed word from its bank at one
// character per cycle unless stem_ready holds the output; the first character
// goes through the registered RAM read once its descriptor is at the queue head.
// The front stalls only while both banks hold words that have not been fully
// read out, so the depth of that overlap is set by the two banks and the
// two-entry descriptor queue. Characters beyond MAX_WORD_LEN are dropped and
// every character of that word carries truncated.
// ----------------------------------------------------------------------------
module suffix_stemmer_step1_core #(
  parameter int MAX_WORD_LEN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_ready,
  input  wire logic [7:0] letter,
  input  wire logic       word_end,
  output logic            stem_valid,
  input  wire logic       stem_ready,
  output logic [7:0]      out_letter,
  output logic            out_end,
  output logic            truncated
);

  localparam int LEN_W     = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W     = $clog2(MAX_WORD_LEN);
  localparam int DESC_W    = LEN_W + 3;
  localparam int RAM_DEPTH = 2 * (1 << IDX_W);

  logic              q_push;
  logic [DESC_W-1:0] q_data;
  logic              q_pop;
  logic [DESC_W-1:0] q_head;
  logic              q_not_empty;
  logic              q_full;
  logic              ram_we;
  logic [IDX_W:0]    ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [IDX_W:0]    ram_raddr;
  logic [7:0]        ram_rdata;

  sss_front #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .letter    (letter),
    .word_end  (word_end),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  sss_queue #(
    .WIDTH(DESC_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  sss_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sss_back #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_head     (q_head),
    .q_not_empty(q_not_empty),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .stem_valid (stem_valid),
    .stem_ready (stem_ready),
    .out_letter (out_letter),
    .out_end    (out_end),
    .truncated  (truncated)
  );

  a_bank_clash : assert property (@(posedge clk) disable iff (rst)
      !(ram_we && ram_re && ram_waddr[IDX_W] == ram_raddr[IDX_W]))
    else $error("Front end wrote the bank being emitted.");
  a_ready_full : assert property (@(posedge clk) disable iff (rst)
      char_ready == !q_full)
    else $error("Input ready disagrees with queue space.");
  a_out_end_pop : assert property (@(posedge clk) disable iff (rst)
      q_pop |=> stem_valid && out_end)
    else $error("Word finished without an end mark.");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Porter step 1 suffix stemmer
// Sends characters grouped into words and checks every stemmed character
// against a scoreboard that stems each word itself.
// ----------------------------------------------------------------------------
module tb_top
  import sss_pkg::*;
();

  localparam int WORD_CAP = 32;
  localparam int RANDOM_CHARS = 460;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [7:0] letter;
    logic       last;
    logic       cut;
  } stem_char_t;

  class stem_scoreboard;
    bit [7:0]     chars[WORD_CAP];
    int unsigned  fill;
    bit           dropped;
    stem_char_t   stem_q[$];
    int           errors;

    task report(string what);
      $display("%0t ns: %s", $time, what);
      errors++;
    endtask

    function int pending();
      return stem_q.size();
    endfunction

    function bit tail_is(string sfx, int unsigned n);
      int unsigned k;
      k = sfx.len();
      if (n < k) return 1'b0;
      for (int i = 0; i < k; i++) begin
        if (chars[n - k + i] != sfx[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int unsigned stem_length(int unsigned n);
      bit cut;
      cut = 1'b0;
      if (n > 4 && tail_is("sses", n)) n -= 2;
      else if (n > 3 && tail_is("ies", n)) n -= 2;
      else if (n > 2 && tail_is("ss", n)) return n;
      else if (n > 1 && chars[n - 1] == CH_S) n -= 1;
      if (n > 4 && tail_is("ing", n)) begin
        n -= 3;
        cut = 1'b1;
      end else if (n > 3 && tail_is("ed", n)) begin
        n -= 2;
        cut = 1'b1;
      end
      if (cut) begin
        if (n >= 2 && (tail_is("at", n) || tail_is("bl", n) || tail_is("iz", n))) begin
          chars[n] = CH_E;
          n += 1;
        end else if (n >= 2 && chars[n - 1] == chars[n - 2]) begin
          n -= 1;
        end else if (n == 3 && tail_is("fil", n)) begin
          chars[n] = CH_E;
          n += 1;
        end
      end
      return n;
    endfunction

    function void note_char(bit [7:0] ch, bit last);
      int unsigned n;
      stem_char_t s;
      if (fill < WORD_CAP) begin
        chars[fill] = ch;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      n = stem_length(fill);
      for (int k = 0; k < n; k++) begin
        s.letter = chars[k];
        s.last = (k + 1 == n);
        s.cut = dropped;
        stem_q.push_back(s);
      end
      fill = 0;
      dropped = 1'b0;
    endfunction

    task check_stem(logic [7:0] ch, logic last, logic cut);
      stem_char_t s;
      if (stem_q.size() == 0) begin
        report($sformatf("unexpected character %02h", ch));
        return;
      end
      s = stem_q.pop_front();
      if (ch !== s.letter)
        report($sformatf("out_letter %02h, expected %02h", ch, s.letter));
      if (last !== s.last)
        report($sformatf("out_end %b, expected %b (letter %02h)", last, s.last, s.letter));
      if (cut !== s.cut)
        report($sformatf("truncated %b, expected %b (letter %02h)", cut, s.cut, s.letter));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       char_valid;
  logic       char_ready;
  logic [7:0] letter;
  logic       word_end;
  logic       stem_valid;
  logic       stem_ready;
  logic [7:0] out_letter;
  logic       out_end;
  logic       truncated;

  stem_scoreboard sb = new();
  bit             hold_output = 1'b0;
  bit             no_gaps = 1'b0;
  int             chars_sent = 0;
  int             cycle_count = 0;
  bit [7:0]       word_buf[$];

  logic [7:0] common_letters[12] = '{CH_A, CH_B, CH_D, CH_E, CH_F, CH_G,
                                     CH_I, CH_L, CH_N, CH_S, CH_T, CH_Z};
  string endings[16] = '{"", "s", "ss", "sses", "ies", "ing", "ed", "ating",
                         "ated", "bling", "bled", "izing", "izes", "eds",
                         "ings", "e"};

  suffix_stemmer_step1_core #(.MAX_WORD_LEN(WORD_CAP)) dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .letter     (letter),
    .word_end   (word_end),
    .stem_valid (stem_valid),
    .stem_ready (stem_ready),
    .out_letter (out_letter),
    .out_end    (out_end),
    .truncated  (truncated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && stem_valid && stem_ready) sb.check_stem(out_letter, out_end, truncated);
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function bit [7:0] pick_letter();
    if ($urandom_range(0, 99) < 85) return common_letters[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  task send_char(bit [7:0] ch, bit last);
    int gap;
    char_valid <= 1'b1;
    letter <= ch;
    word_end <= last;
    do @(posedge clk); while (!char_ready);
    sb.note_char(ch, last);
    chars_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task send_word_buf();
    for (int i = 0; i < word_buf.size(); i++) send_char(word_buf[i], i == word_buf.size() - 1);
  endtask

  task build_word();
    int    stem_len;
    string sfx;
    word_buf.delete();
    if ($urandom_range(0, 24) == 0) stem_len = $urandom_range(26, 40);
    else stem_len = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) begin
      word_buf.push_back(CH_F);
      word_buf.push_back(CH_I);
      word_buf.push_back(CH_L);
    end else begin
      for (int i = 0; i < stem_len; i++) word_buf.push_back(pick_letter());
      if (word_buf.size() > 0 && $urandom_range(0, 3) == 0)
        word_buf.push_back(word_buf[word_buf.size() - 1]);
    end
    if ($urandom_range(0, 9) < 8) begin
      sfx = endings[$urandom_range(0, 15)];
      for (int i = 0; i < sfx.len(); i++) word_buf.push_back(sfx[i]);
    end
    if (word_buf.size() == 0) word_buf.push_back(pick_letter());
  endtask

  initial begin
    int run;
    int stall;
    stem_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_output) begin
        stem_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) run = $urandom_range(40, 150);
      else run = $urandom_range(1, 20);
      stall = pick_gap();
      stem_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        stem_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int words;
    rst <= 1'b1;
    char_valid <= 1'b0;
    letter <= 8'h00;
    word_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("ponies");
    send_text("hopped");
    send_text("filing");
    send_text("s");
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);
    send_text("cats");

    words = 0;
    while (chars_sent < RANDOM_CHARS) begin
      no_gaps = ($urandom_range(0, 9) < 3);
      if (words == 25) hold_output = 1'b1;
      if (words == 40) begin
        char_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      build_word();
      send_word_buf();
      words++;
    end
    char_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
